// ===== rtl/core/ssm_pkg.sv =====
// shared types, constants and key helpers of the sorted stream merge
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

    localparam int MAX_STREAMS = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int FIELD_W     = 32;
    localparam int REC_W       = 3 * FIELD_W + 1;
    localparam int DATA_W      = ((REC_W + 7) / 8) * 8;
    localparam int USER_W      = IDX_W + 1;
    localparam int KEY_W       = 2 * FIELD_W + 1;

    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_END,
        KIND_RECORD
    } ssm_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } ssm_state_t;

    typedef struct packed {
        ssm_kind_t            kind;
        logic [IDX_W-1:0]     index;
        logic [FIELD_W-1:0]   reference_id;
        logic [FIELD_W-1:0]   position;
        logic                 strand;
        logic [FIELD_W-1:0]   record_tag;
    } ssm_item_t;

    // sign-flipped fields so that an unsigned compare orders signed values
    function automatic logic [KEY_W-1:0] order_key(
        input logic [FIELD_W-1:0] reference_id,
        input logic [FIELD_W-1:0] position,
        input logic               strand
    );
        return {~reference_id[FIELD_W-1], reference_id[FIELD_W-2:0],
                ~position[FIELD_W-1], position[FIELD_W-2:0], strand};
    endfunction

    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] n;
        n = value;
        if (value == '0)
        begin
            n = CNT_W'(1);
        end
        else if (value > CNT_W'(MAX_STREAMS))
        begin
            n = CNT_W'(MAX_STREAMS);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssm_front.sv =====
// input side: accepts items, classifies them and queues them for the merge engine
`timescale 1ns / 1ps
`default_nettype none

module ssm_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // reference_id, position, strand, record_tag, zero pad
    input  wire logic [ssm_pkg::DATA_W-1:0]     s_axis_tdata,
    // stream_index, stream_ended
    input  wire logic [ssm_pkg::USER_W-1:0]     s_axis_tuser,
    input  wire logic [ssm_pkg::CNT_W-1:0]      active_n,
    output logic                                pop_valid,
    input  wire logic                           pop_ready,
    output ssm_pkg::ssm_item_t                  pop_item
);

    localparam int FW = ssm_pkg::FIELD_W;

    ssm_pkg::ssm_item_t in_item;
    ssm_pkg::ssm_item_t q_mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push;
    logic               pop;

    always_comb
    begin
        in_item.index        = s_axis_tuser[ssm_pkg::IDX_W-1:0];
        in_item.reference_id = s_axis_tdata[FW-1:0];
        in_item.position     = s_axis_tdata[2*FW-1:FW];
        in_item.strand       = s_axis_tdata[2*FW];
        in_item.record_tag   = s_axis_tdata[3*FW:2*FW+1];
        if ({1'b0, in_item.index} >= active_n)
        begin
            in_item.kind = ssm_pkg::KIND_IGNORE;
        end
        else if (s_axis_tuser[ssm_pkg::IDX_W])
        begin
            in_item.kind = ssm_pkg::KIND_END;
        end
        else
        begin
            in_item.kind = ssm_pkg::KIND_RECORD;
        end
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign pop_valid     = (count_reg != 2'd0);
    assign pop_item      = q_mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssm_back.sv =====
// merge engine: head slots, sequential minimum scan and output register
`timescale 1ns / 1ps
`default_nettype none

module ssm_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ssm_pkg::CNT_W-1:0]      active_n,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire ssm_pkg::ssm_item_t             pop_item,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_reference_id, out_position, out_strand, out_tag, zero pad
    output logic [ssm_pkg::DATA_W-1:0]          m_axis_tdata,
    // source_stream, all_done
    output logic [ssm_pkg::USER_W-1:0]          m_axis_tuser
);

    localparam int FW = ssm_pkg::FIELD_W;
    localparam int IW = ssm_pkg::IDX_W;
    localparam int KW = ssm_pkg::KEY_W;
    localparam int NS = ssm_pkg::MAX_STREAMS;

    ssm_pkg::ssm_state_t state_reg, state_next;

    logic [FW-1:0]  head_ref_mem    [NS];
    logic [FW-1:0]  head_pos_mem    [NS];
    logic           head_strand_mem [NS];
    logic [FW-1:0]  head_tag_mem    [NS];
    logic [NS-1:0]  slot_full_reg;
    logic [NS-1:0]  slot_finished_reg;

    logic [IW-1:0]  scan_idx_reg;
    logic           any_full_reg;
    logic           all_ready_reg;
    logic [IW-1:0]  best_idx_reg;
    logic [KW-1:0]  best_key_reg;
    logic [FW-1:0]  best_tag_reg;

    logic                          out_valid_reg;
    logic [ssm_pkg::DATA_W-1:0]    out_data_reg;
    logic [ssm_pkg::USER_W-1:0]    out_user_reg;

    logic           pop_fire;
    logic           scan_step;
    logic           emit_fire;
    logic           out_free;
    logic           write_head;
    logic [IW-1:0]  last_idx;
    logic [KW-1:0]  cand_key;
    logic           cand_full;
    logic           cand_wins;
    logic [FW-1:0]  best_ref;
    logic [FW-1:0]  best_pos;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign last_idx   = IW'(active_n - ssm_pkg::CNT_W'(1));
    assign write_head = pop_fire && (pop_item.kind == ssm_pkg::KIND_RECORD)
                        && !slot_finished_reg[pop_item.index];

    assign cand_key  = ssm_pkg::order_key(head_ref_mem[scan_idx_reg],
                                          head_pos_mem[scan_idx_reg],
                                          head_strand_mem[scan_idx_reg]);
    assign cand_full = slot_full_reg[scan_idx_reg];
    assign cand_wins = cand_full && (!any_full_reg || (cand_key < best_key_reg));

    assign best_ref = {~best_key_reg[KW-1], best_key_reg[KW-2:FW+1]};
    assign best_pos = {~best_key_reg[FW], best_key_reg[FW-1:1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ssm_pkg::ST_SCAN;
                end
            end
            ssm_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == last_idx)
                begin
                    state_next = ssm_pkg::ST_EMIT;
                end
            end
            ssm_pkg::ST_EMIT:
            begin
                if (!all_ready_reg || out_free)
                begin
                    state_next = ssm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssm_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop_ready = 1'b0;
        scan_step = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                pop_ready = 1'b1;
            end
            ssm_pkg::ST_SCAN:
            begin
                scan_step = 1'b1;
            end
            ssm_pkg::ST_EMIT:
            begin
                emit_fire = all_ready_reg && out_free;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    assign pop_fire = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_full_reg     <= '0;
            slot_finished_reg <= '0;
        end
        else
        begin
            if (pop_fire && (pop_item.kind == ssm_pkg::KIND_END))
            begin
                slot_finished_reg[pop_item.index] <= 1'b1;
            end
            if (write_head)
            begin
                slot_full_reg[pop_item.index] <= 1'b1;
            end
            if (emit_fire && any_full_reg)
            begin
                slot_full_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // head records
    always_ff @(posedge clk)
    begin
        if (write_head)
        begin
            head_ref_mem[pop_item.index]    <= pop_item.reference_id;
            head_pos_mem[pop_item.index]    <= pop_item.position;
            head_strand_mem[pop_item.index] <= pop_item.strand;
            head_tag_mem[pop_item.index]    <= pop_item.record_tag;
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            any_full_reg  <= 1'b0;
            all_ready_reg <= 1'b0;
        end
        else if (pop_fire)
        begin
            scan_idx_reg  <= '0;
            any_full_reg  <= 1'b0;
            all_ready_reg <= 1'b1;
        end
        else if (scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IW'(1);
            if (cand_full)
            begin
                any_full_reg <= 1'b1;
            end
            else if (!slot_finished_reg[scan_idx_reg])
            begin
                all_ready_reg <= 1'b0;
            end
        end
    end

    // running minimum
    always_ff @(posedge clk)
    begin
        if (scan_step && cand_wins)
        begin
            best_idx_reg <= scan_idx_reg;
            best_key_reg <= cand_key;
            best_tag_reg <= head_tag_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            if (any_full_reg)
            begin
                out_user_reg <= {1'b0, best_idx_reg};
                out_data_reg <= {(ssm_pkg::DATA_W - ssm_pkg::REC_W)'(0),
                                 best_tag_reg, best_key_reg[0], best_pos, best_ref};
            end
            else
            begin
                out_user_reg <= {1'b1, IW'(0)};
                out_data_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_stream_merge_core.sv =====
// top level of the sorted stream merge: config register, input queue, merge engine
//
// k-way merge of up to eight sorted record streams.
// s_axis carries one stream's next head record, or an end marker when
// tuser bit 3 (stream_ended) is set; tuser[2:0] names the stream.
// m_axis returns at most one item per input item: the smallest held head by
// (reference id, position, strand), ties to the lowest stream, with its source
// stream in tuser[2:0], or a done item (tuser bit 3, all other bits zero) once
// every stream in use has ended and no head is held.
// cfg_data sets streams_in_use (0 acts as 1, above 8 acts as 8); write it idle.
// each item passes through the merge engine in order: a step to update the slot, a
// scan of each slot in use through the shared key comparator, and a step to emit
// the result into the output register.
// a two-entry queue takes new items while the engine scans.
// a stalled m_axis holds its item; the engine then waits in its emit step when it
// has a further item to emit, and the queue fills, after which s_axis_tready drops.
// reset empties all slots, clears ended flags and sets streams_in_use to 8.
`timescale 1ns / 1ps
`default_nettype none

module sorted_stream_merge_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ssm_pkg::CNT_W-1:0]      cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // reference_id, position, strand, record_tag, zero pad
    input  wire logic [ssm_pkg::DATA_W-1:0]     s_axis_tdata,
    // stream_index, stream_ended
    input  wire logic [ssm_pkg::USER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_reference_id, out_position, out_strand, out_tag, zero pad
    output logic [ssm_pkg::DATA_W-1:0]          m_axis_tdata,
    // source_stream, all_done
    output logic [ssm_pkg::USER_W-1:0]          m_axis_tuser
);

    logic [ssm_pkg::CNT_W-1:0] streams_in_use_reg;
    logic [ssm_pkg::CNT_W-1:0] active_n;
    logic                      pop_valid;
    logic                      pop_ready;
    ssm_pkg::ssm_item_t        pop_item;

    assign cfg_ready = 1'b1;
    assign active_n  = ssm_pkg::active_count(streams_in_use_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streams_in_use_reg <= ssm_pkg::CNT_W'(ssm_pkg::MAX_STREAMS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            streams_in_use_reg <= cfg_data;
        end
    end

    ssm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .active_n      (active_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item)
    );

    ssm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_n      (active_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ssm_checker.sv =====
// port-level checks of the sorted stream merge output channel
`timescale 1ns / 1ps
`default_nettype none

module ssm_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [ssm_pkg::DATA_W-1:0]     m_axis_tdata,
    input  wire logic [ssm_pkg::USER_W-1:0]     m_axis_tuser
);

    localparam int IW = ssm_pkg::IDX_W;

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // valid drops only after a taken item
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("output item withdrawn");

    // done item carries no record and no source
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[IW] |->
            (m_axis_tdata == '0) && (m_axis_tuser[IW-1:0] == '0))
        else $error("done item with nonzero fields");

    // pad bits above the record stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[ssm_pkg::DATA_W-1:ssm_pkg::REC_W] == '0))
        else $error("nonzero pad bits in output item");

endmodule

bind sorted_stream_merge_core ssm_checker u_ssm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
